### rtl/jtl_pkg.sv
// ----------------------------------------------------------------------------
// jtl_pkg
// shared types, character codes and helpers for the json token lexer
// ----------------------------------------------------------------------------
package jtl_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 16;
    localparam int MAX_RECS    = 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_BITS    = 2;
    localparam int CNT_BITS    = 3;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_NUM,
        MODE_WORD
    } lex_mode_t;

    typedef enum logic [2:0] {
        KIND_PUNCT,
        KIND_STRING,
        KIND_NUMBER,
        KIND_WORD,
        KIND_END,
        KIND_ERROR
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic [7:0]              punct;
        logic [OFFSET_BITS-1:0]  start;
        logic [LENGTH_BITS-1:0]  length;
        logic                    saturated;
        logic                    last;
    } rec_t;

    typedef struct packed {
        rec_t [MAX_RECS-1:0] rec;
        logic [1:0]          count;
    } step_out_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LBRACK) ||
               (b == CH_RBRACK) || (b == CH_COMMA) || (b == CH_COLON);
    endfunction

    function automatic rec_t make_rec(
        input kind_t                  kind,
        input logic [7:0]             punct,
        input logic [OFFSET_BITS-1:0] start,
        input logic [LENGTH_BITS-1:0] length,
        input logic                   saturated
    );
        rec_t r;
        r.kind      = kind;
        r.punct     = punct;
        r.start     = start;
        r.length    = length;
        r.saturated = saturated;
        r.last      = 1'b0;
        return r;
    endfunction

endpackage

### rtl/jtl_core.sv
// ----------------------------------------------------------------------------
// jtl_core
// lexer state and the per-byte token logic; yields up to three records a byte
// ----------------------------------------------------------------------------
module jtl_core
    import jtl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       end_of_text,
    output step_out_t  result
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
    localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);

    lex_mode_t              mode_reg, mode_next;
    logic                   dot_reg, dot_next;
    logic                   exp_reg, exp_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic                   over_reg, over_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;

    logic [LENGTH_BITS-1:0] len_grow;
    logic                   over_grow;
    logic                   taken;
    logic                   ended;
    logic [1:0]             n;
    rec_t [MAX_RECS-1:0]    recs;

    assign len_grow  = (len_reg == LEN_MAX) ? len_reg : len_reg + LEN_ONE;
    assign over_grow = over_reg | (len_reg == LEN_MAX);

    always_comb
    begin
        mode_next   = mode_reg;
        dot_next    = dot_reg;
        exp_next    = exp_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        over_next   = over_reg;
        offset_next = offset_reg;
        taken       = 1'b1;
        ended       = 1'b0;
        n           = 2'd0;
        recs        = '0;

        case (mode_reg)
            MODE_STR:
            begin
                len_next  = len_grow;
                over_next = over_grow;
                if (data_byte == CH_QUOTE)
                begin
                    recs[n] = make_rec(KIND_STRING, 8'h00, start_reg, len_grow, over_grow);
                    n = n + 2'd1;
                    mode_next = MODE_IDLE;
                end
                else if (data_byte == CH_BSLASH)
                begin
                    mode_next = MODE_ESC;
                end
            end
            MODE_ESC:
            begin
                len_next  = len_grow;
                over_next = over_grow;
                mode_next = MODE_STR;
            end
            MODE_NUM:
            begin
                if (is_digit(data_byte))
                begin
                    len_next  = len_grow;
                    over_next = over_grow;
                end
                else if (data_byte == CH_DOT && !dot_reg)
                begin
                    dot_next  = 1'b1;
                    len_next  = len_grow;
                    over_next = over_grow;
                end
                else if ((data_byte == CH_LOW_E || data_byte == CH_UP_E) && !exp_reg)
                begin
                    exp_next  = 1'b1;
                    len_next  = len_grow;
                    over_next = over_grow;
                end
                else
                begin
                    recs[n] = make_rec(KIND_NUMBER, 8'h00, start_reg, len_reg, over_reg);
                    n = n + 2'd1;
                    mode_next = MODE_IDLE;
                    taken = 1'b0;
                end
            end
            MODE_WORD:
            begin
                if (is_letter(data_byte))
                begin
                    len_next  = len_grow;
                    over_next = over_grow;
                end
                else
                begin
                    recs[n] = make_rec(KIND_WORD, 8'h00, start_reg, len_reg, over_reg);
                    n = n + 2'd1;
                    mode_next = MODE_IDLE;
                    taken = 1'b0;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                taken = 1'b0;
            end
        endcase

        if (!taken)
        begin
            if (is_space(data_byte))
            begin
                mode_next = MODE_IDLE;
            end
            else if (data_byte == CH_QUOTE || is_digit(data_byte) ||
                     data_byte == CH_MINUS || data_byte == CH_PLUS ||
                     !(is_punct(data_byte) || data_byte == CH_NUL))
            begin
                if (data_byte == CH_QUOTE)
                    mode_next = MODE_STR;
                else if (is_digit(data_byte) || data_byte == CH_MINUS ||
                         data_byte == CH_PLUS)
                    mode_next = MODE_NUM;
                else
                    mode_next = MODE_WORD;
                start_next = offset_reg;
                len_next   = LEN_ONE;
                over_next  = 1'b0;
                dot_next   = 1'b0;
                exp_next   = 1'b0;
            end
            else if (is_punct(data_byte))
            begin
                recs[n] = make_rec(KIND_PUNCT, data_byte, offset_reg, LEN_ONE, 1'b0);
                n = n + 2'd1;
            end
            else
            begin
                recs[n] = make_rec(KIND_END, 8'h00, offset_reg, '0, 1'b0);
                n = n + 2'd1;
                ended = 1'b1;
            end
        end

        if (end_of_text && !ended)
        begin
            if (mode_next == MODE_NUM)
            begin
                recs[n] = make_rec(KIND_NUMBER, 8'h00, start_next, len_next, over_next);
                n = n + 2'd1;
            end
            else if (mode_next == MODE_WORD)
            begin
                recs[n] = make_rec(KIND_WORD, 8'h00, start_next, len_next, over_next);
                n = n + 2'd1;
            end
            else if (mode_next == MODE_STR || mode_next == MODE_ESC)
            begin
                recs[n] = make_rec(KIND_ERROR, 8'h00, start_next, len_next, over_next);
                n = n + 2'd1;
            end
            recs[n] = make_rec(KIND_END, 8'h00, offset_reg + OFF_ONE, '0, 1'b0);
            n = n + 2'd1;
            ended = 1'b1;
        end

        if (ended)
        begin
            mode_next   = MODE_IDLE;
            dot_next    = 1'b0;
            exp_next    = 1'b0;
            start_next  = '0;
            len_next    = '0;
            over_next   = 1'b0;
            offset_next = '0;
        end
        else
        begin
            offset_next = offset_reg + OFF_ONE;
        end

        if (n != 2'd0)
            recs[n - 2'd1].last = 1'b1;

        result.rec   = recs;
        result.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            dot_reg    <= 1'b0;
            exp_reg    <= 1'b0;
            start_reg  <= '0;
            len_reg    <= '0;
            over_reg   <= 1'b0;
            offset_reg <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            dot_reg    <= dot_next;
            exp_reg    <= exp_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            over_reg   <= over_next;
            offset_reg <= offset_next;
        end
    end

endmodule

### rtl/json_token_lexer_unit.sv
// ----------------------------------------------------------------------------
// json_token_lexer_unit
// streaming json tokenizer: one text byte in, zero to three token records out
// ----------------------------------------------------------------------------
// input channel: data_byte and end_of_text under in_valid / in_ready, one
// byte of text per word. output channel: one token record per word under
// out_valid / out_ready; last_of_run marks the final record of a byte.
// a byte is held in an input register, then the combinational lexer logic
// writes all records of that byte into a four-entry record queue; the
// output is driven from the head of that queue.
// throughput: one byte per cycle while out_ready stays high and each byte
// yields at most one record; a byte that yields n records takes n output
// words.
// the lexer step waits until the queue has room for three records, so a
// stalled receiver backs up into the input register and then drops in_ready.
// reset clears the lexer state (idle, offset zero), the input register and
// the queue; an end record or a nul between tokens returns the lexer to the
// same state for the next text.
// ----------------------------------------------------------------------------
module json_token_lexer_unit
    import jtl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_text,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             token_kind,
    output logic [7:0]             punct_char,
    output logic [OFFSET_BITS-1:0] token_offset,
    output logic [LENGTH_BITS-1:0] token_length,
    output logic                   length_saturated,
    output logic                   last_of_run
);

    localparam logic [CNT_BITS-1:0] ROOM_LIMIT = CNT_BITS'(FIFO_DEPTH - MAX_RECS);

    logic                in_full_reg, in_full_next;
    logic [7:0]          byte_reg;
    logic                eot_reg;
    logic                step;
    logic                in_fire;
    logic                pop;
    step_out_t           result;

    rec_t                fifo_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    rec_t                head;

    assign step     = in_full_reg && (count_reg <= ROOM_LIMIT);
    assign in_ready = !in_full_reg || step;
    assign in_fire  = in_valid && in_ready;
    assign pop      = out_valid && out_ready;

    jtl_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (byte_reg),
        .end_of_text (eot_reg),
        .result      (result)
    );

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_fire)
            in_full_next = 1'b1;
        else if (step)
            in_full_next = 1'b0;

        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (step)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_BITS'(result.count);
            count_next  = count_next + CNT_BITS'(result.count);
        end
        rd_ptr_next = rd_ptr_reg;
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_BITS'(1);
            count_next  = count_next - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_reg <= data_byte;
            eot_reg  <= end_of_text;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RECS; i++)
        begin
            if (step && (i < int'(result.count)))
                fifo_reg[wr_ptr_reg + PTR_BITS'(i)] <= result.rec[i];
        end
    end

    assign head             = fifo_reg[rd_ptr_reg];
    assign out_valid        = (count_reg != '0);
    assign token_kind       = head.kind;
    assign punct_char       = head.punct;
    assign token_offset     = head.start;
    assign token_length     = head.length;
    assign length_saturated = head.saturated;
    assign last_of_run      = head.last;

    // queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(FIFO_DEPTH))
    else $error("record queue overfilled");

    // records of one byte are queued together, so a non-final one has a sibling behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_run) |-> (count_reg >= CNT_BITS'(2)))
    else $error("record run split in queue");

    // a lexer step only happens with room for a full run of records
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (count_reg <= CNT_BITS'(FIFO_DEPTH)) && ($past(count_reg) <= ROOM_LIMIT))
    else $error("lexer step without queue room");

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for json_token_lexer_unit: a queue-fed driver sends
// text bytes, a clocked monitor predicts the token records of every accepted
// byte and compares each record that leaves the block, field by field.
// stimulus is a directed opening, then random json-like texts with noise
// under three idle profiles.
// ----------------------------------------------------------------------------
module testbench
    import jtl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 150;

    typedef struct packed {
        logic [7:0] b;
        logic       eot;
    } text_byte_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             data_byte = 8'h00;
    logic                   end_of_text = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [2:0]             token_kind;
    logic [7:0]             punct_char;
    logic [OFFSET_BITS-1:0] token_offset;
    logic [LENGTH_BITS-1:0] token_length;
    logic                   length_saturated;
    logic                   last_of_run;

    text_byte_t pending_bytes[$];
    text_byte_t next_byte;
    rec_t       expected_recs[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  in_took = 1'b0;
    int  cycle_count = 0;
    int  mismatch_count = 0;
    int  bytes_accepted = 0;
    int  records_checked = 0;
    int  saturated_seen = 0;
    int  kind_seen[6];

    // predictor state
    lex_mode_t              lx_mode = MODE_IDLE;
    logic                   in_dot = 1'b0;
    logic                   in_exp = 1'b0;
    logic [OFFSET_BITS-1:0] tok_start = '0;
    logic [LENGTH_BITS-1:0] tok_len = '0;
    logic                   tok_over = 1'b0;
    logic [OFFSET_BITS-1:0] next_off = '0;

    json_token_lexer_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .end_of_text      (end_of_text),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .token_kind       (token_kind),
        .punct_char       (punct_char),
        .token_offset     (token_offset),
        .token_length     (token_length),
        .length_saturated (length_saturated),
        .last_of_run      (last_of_run)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic is_numeral(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    function automatic logic is_mark(input logic [7:0] b);
        return b == CH_LBRACE || b == CH_RBRACE || b == CH_LBRACK ||
               b == CH_RBRACK || b == CH_COMMA || b == CH_COLON;
    endfunction

    function automatic rec_t token_rec(
        input kind_t                  k,
        input logic [7:0]             p,
        input logic [OFFSET_BITS-1:0] s,
        input logic [LENGTH_BITS-1:0] l,
        input logic                   o
    );
        rec_t r;
        r.kind      = k;
        r.punct     = p;
        r.start     = s;
        r.length    = l;
        r.saturated = o;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic rec_t open_token_rec(input kind_t k);
        return token_rec(k, 8'h00, tok_start, tok_len, tok_over);
    endfunction

    function automatic void reset_lexer();
        lx_mode   = MODE_IDLE;
        in_dot    = 1'b0;
        in_exp    = 1'b0;
        tok_start = '0;
        tok_len   = '0;
        tok_over  = 1'b0;
        next_off  = '0;
    endfunction

    function automatic void start_token(input lex_mode_t m, input logic [OFFSET_BITS-1:0] s);
        lx_mode   = m;
        tok_start = s;
        tok_len   = LENGTH_BITS'(1);
        tok_over  = 1'b0;
        in_dot    = 1'b0;
        in_exp    = 1'b0;
    endfunction

    function automatic void grow_token();
        if (tok_len == {LENGTH_BITS{1'b1}})
            tok_over = 1'b1;
        else
            tok_len = tok_len + LENGTH_BITS'(1);
    endfunction

    function automatic void predict_tokens(input logic [7:0] b, input logic eot);
        rec_t                   run[$];
        rec_t                   r;
        logic [OFFSET_BITS-1:0] off;
        logic [OFFSET_BITS-1:0] after;
        logic                   taken;
        logic                   ended;
        off   = next_off;
        after = off + OFFSET_BITS'(1);
        taken = 1'b1;
        ended = 1'b0;
        case (lx_mode)
            MODE_STR:
            begin
                grow_token();
                if (b == CH_QUOTE)
                begin
                    run.push_back(open_token_rec(KIND_STRING));
                    lx_mode = MODE_IDLE;
                end
                else if (b == CH_BSLASH)
                    lx_mode = MODE_ESC;
            end
            MODE_ESC:
            begin
                grow_token();
                lx_mode = MODE_STR;
            end
            MODE_NUM:
            begin
                if (is_numeral(b))
                    grow_token();
                else if (b == CH_DOT && !in_dot)
                begin
                    in_dot = 1'b1;
                    grow_token();
                end
                else if ((b == CH_LOW_E || b == CH_UP_E) && !in_exp)
                begin
                    in_exp = 1'b1;
                    grow_token();
                end
                else
                begin
                    run.push_back(open_token_rec(KIND_NUMBER));
                    lx_mode = MODE_IDLE;
                    taken = 1'b0;
                end
            end
            MODE_WORD:
            begin
                if (is_alpha(b))
                    grow_token();
                else
                begin
                    run.push_back(open_token_rec(KIND_WORD));
                    lx_mode = MODE_IDLE;
                    taken = 1'b0;
                end
            end
            default:
            begin
                lx_mode = MODE_IDLE;
                taken = 1'b0;
            end
        endcase

        if (!taken)
        begin
            if (is_blank(b))
                ;
            else if (b == CH_QUOTE)
                start_token(MODE_STR, off);
            else if (is_mark(b))
                run.push_back(token_rec(KIND_PUNCT, b, off, LENGTH_BITS'(1), 1'b0));
            else if (is_numeral(b) || b == CH_MINUS || b == CH_PLUS)
                start_token(MODE_NUM, off);
            else if (b == CH_NUL)
            begin
                run.push_back(token_rec(KIND_END, 8'h00, off, '0, 1'b0));
                ended = 1'b1;
            end
            else
                start_token(MODE_WORD, off);
        end

        if (eot && !ended)
        begin
            if (lx_mode == MODE_NUM)
                run.push_back(open_token_rec(KIND_NUMBER));
            else if (lx_mode == MODE_WORD)
                run.push_back(open_token_rec(KIND_WORD));
            else if (lx_mode == MODE_STR || lx_mode == MODE_ESC)
                run.push_back(open_token_rec(KIND_ERROR));
            run.push_back(token_rec(KIND_END, 8'h00, after, '0, 1'b0));
            ended = 1'b1;
        end

        if (ended)
            reset_lexer();
        else
            next_off = after;

        if (run.size() != 0)
        begin
            r = run.pop_back();
            r.last = 1'b1;
            run.push_back(r);
        end
        foreach (run[i])
            expected_recs.push_back(run[i]);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s at record %0d: got %0h, want %0h",
                 what, records_checked, got, want);
        mismatch_count++;
    endtask

    // monitor: check leaving records, then predict from the accepted word
    always @(posedge clk)
    begin
        rec_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (out_valid && out_ready)
            begin
                if (expected_recs.size() == 0)
                    report_mismatch("unexpected record kind", 64'(token_kind), '0);
                else
                begin
                    want = expected_recs.pop_front();
                    if (token_kind !== want.kind)
                        report_mismatch("token_kind", 64'(token_kind), 64'(want.kind));
                    if (punct_char !== want.punct)
                        report_mismatch("punct_char", 64'(punct_char), 64'(want.punct));
                    if (token_offset !== want.start)
                        report_mismatch("token_offset", 64'(token_offset),
                                        64'(want.start));
                    if (token_length !== want.length)
                        report_mismatch("token_length", 64'(token_length),
                                        64'(want.length));
                    if (length_saturated !== want.saturated)
                        report_mismatch("length_saturated", 64'(length_saturated),
                                        64'(want.saturated));
                    if (last_of_run !== want.last)
                        report_mismatch("last_of_run", 64'(last_of_run), 64'(want.last));
                    kind_seen[want.kind]++;
                    if (want.saturated)
                        saturated_seen++;
                end
                records_checked++;
            end
            in_took = in_valid && in_ready;
            if (in_took)
            begin
                predict_tokens(data_byte, end_of_text);
                bytes_accepted++;
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            data_byte   <= 8'h00;
            end_of_text <= 1'b0;
            out_ready   <= 1'b0;
        end
        else
        begin
            if (!in_valid || in_took)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_byte = pending_bytes.pop_front();
                    in_valid    <= 1'b1;
                    data_byte   <= next_byte.b;
                    end_of_text <= next_byte.eot;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b, input logic eot);
        text_byte_t t;
        t.b   = b;
        t.eot = eot;
        pending_bytes.push_back(t);
    endtask

    task automatic push_chars(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], 1'b0);
    endtask

    task automatic flag_last_eot();
        text_byte_t t;
        if (pending_bytes.size() != 0)
        begin
            t = pending_bytes.pop_back();
            t.eot = 1'b1;
            pending_bytes.push_back(t);
        end
    endtask

    task automatic gen_string();
        int         n;
        logic [7:0] c;
        push_byte(CH_QUOTE, 1'b0);
        n = $urandom_range(0, 8);
        repeat (n)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                push_byte(CH_BSLASH, 1'b0);
                push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            else
            begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_QUOTE || c == CH_BSLASH)
                    c = "a";
                push_byte(c, 1'b0);
            end
        end
        if ($urandom_range(0, 9) != 0)
            push_byte(CH_QUOTE, 1'b0);
    endtask

    task automatic gen_number();
        if ($urandom_range(0, 2) == 0)
            push_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS, 1'b0);
        repeat ($urandom_range(1, 5))
            push_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
        if ($urandom_range(0, 1) == 0)
        begin
            push_byte(CH_DOT, 1'b0);
            repeat ($urandom_range(0, 3))
                push_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            push_byte($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E, 1'b0);
            repeat ($urandom_range(1, 2))
                push_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
        end
        if ($urandom_range(0, 7) == 0)
            push_byte($urandom_range(0, 1) ? CH_DOT : CH_LOW_E, 1'b0);
    endtask

    task automatic gen_word();
        string keywords[3] = '{"true", "false", "null"};
        if ($urandom_range(0, 1) == 0)
            push_chars(keywords[$urandom_range(0, 2)]);
        else
        begin
            if ($urandom_range(0, 3) == 0)
                push_byte(8'($urandom_range(128, 255)), 1'b0);
            repeat ($urandom_range(1, 6))
                push_byte(8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25)),
                          1'b0);
        end
    endtask

    task automatic gen_texts(input int goal);
        logic [7:0] marks[6] = '{CH_LBRACE, CH_RBRACE, CH_LBRACK,
                                 CH_RBRACK, CH_COMMA, CH_COLON};
        logic [7:0] blanks[4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
        int         base;
        int         pick;
        base = pending_bytes.size();
        while (pending_bytes.size() - base < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                push_byte(marks[$urandom_range(0, 5)], 1'b0);
            else if (pick < 25)
                repeat ($urandom_range(1, 3))
                    push_byte(blanks[$urandom_range(0, 3)], 1'b0);
            else if (pick < 45)
                gen_string();
            else if (pick < 65)
                gen_number();
            else if (pick < 80)
                gen_word();
            else if (pick < 89)
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            else
            begin
                case ($urandom_range(0, 3))
                    0: flag_last_eot();
                    1: push_byte(CH_NUL, 1'b0);
                    2: push_byte(CH_NUL, 1'b1);
                    default: push_byte(8'($urandom_range(0, 255)), 1'b1);
                endcase
            end
        end
    endtask

    task automatic drain();
        while (pending_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_recs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 38;
        recv_idle_pct = 85;
        push_chars("{}[],:");
        push_byte(CH_SPACE, 1'b0);
        push_byte(CH_TAB, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_byte(CH_CR, 1'b0);
        // escaped quote and nul as string content
        push_byte(CH_QUOTE, 1'b0);
        push_byte(CH_BSLASH, 1'b0);
        push_byte(CH_QUOTE, 1'b0);
        push_byte(CH_NUL, 1'b0);
        push_byte(CH_QUOTE, 1'b0);
        // second dot ends the number and starts a word, then nul ends the word
        push_chars("1..");
        push_byte(CH_NUL, 1'b0);
        // second exponent, then a top byte with the end flag
        push_chars("+eE");
        push_byte(8'hFF, 1'b1);
        // unterminated string
        push_byte(CH_QUOTE, 1'b0);
        push_byte("x", 1'b1);
        push_byte(CH_NUL, 1'b1);
        drain();
        gen_texts(PHASE_ITEMS);
        drain();

        send_idle_pct = 85;
        recv_idle_pct = 38;
        gen_texts(PHASE_ITEMS);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        gen_texts(PHASE_ITEMS);
        push_byte(CH_NUL, 1'b1);
        drain();

        $display("covered %0d text bytes and %0d token records in %0d cycles",
                 bytes_accepted, records_checked, cycle_count);
        $display("punct %0d, string %0d, number %0d, word %0d, end %0d, error %0d, saturated %0d",
                 kind_seen[KIND_PUNCT], kind_seen[KIND_STRING], kind_seen[KIND_NUMBER],
                 kind_seen[KIND_WORD], kind_seen[KIND_END], kind_seen[KIND_ERROR],
                 saturated_seen);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
rtl/jtl_pkg.sv
rtl/jtl_core.sv
rtl/json_token_lexer_unit.sv
dv/testbench.sv
